@@ design/swarq_pkg.sv @@
// shared types, codes and helpers for the sliding window arq control block
// no dependencies; used by every module under design/
`timescale 1ns / 1ps

package swarq_pkg;

	// sequence numbers and window count
	localparam int SEQ_W       = 3;
	localparam int WINDOWS_DEF = 4;

	// input event codes
	localparam logic [2:0] ACT_CHECK   = 3'd0;
	localparam logic [2:0] ACT_WRITE   = 3'd1;
	localparam logic [2:0] ACT_ACK     = 3'd2;
	localparam logic [2:0] ACT_NAK     = 3'd3;
	localparam logic [2:0] ACT_EOS     = 3'd4;
	localparam logic [2:0] ACT_SEND    = 3'd5;
	localparam logic [2:0] ACT_TIMEOUT = 3'd6;

	// result codes
	localparam logic [2:0] KIND_ACK     = 3'd0;
	localparam logic [2:0] KIND_NAK     = 3'd1;
	localparam logic [2:0] KIND_DELIVER = 3'd2;
	localparam logic [2:0] KIND_CHECK   = 3'd3;
	localparam logic [2:0] KIND_XMIT    = 3'd4;
	localparam logic [2:0] KIND_ILLNAK  = 3'd5;
	localparam logic [2:0] KIND_FULL    = 3'd6;
	localparam logic [2:0] KIND_ARM     = 3'd7;

	typedef struct packed {
		logic [2:0]       action;
		logic [SEQ_W-1:0] window;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [SEQ_W-1:0] seq;
		logic             last;
	} out_item_t;

	// classified command handed from front to back
	typedef enum logic [2:0] {
		OP_CHECK,
		OP_WRITE,
		OP_ACK,
		OP_NAK,
		OP_EOS,
		OP_SEND,
		OP_TIMEOUT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [SEQ_W-1:0] window;
		logic             flush_if_held;
		logic             flush_always;
	} cmd_t;

	// index of the lowest set bit of an 8-bit map
	function automatic logic [SEQ_W-1:0] lowest_set(input logic [7:0] map);
		logic [SEQ_W-1:0] idx;
		idx = '0;
		for (int i = 7; i >= 0; i--) begin
			if (map[i]) begin
				idx = SEQ_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

@@ design/swarq_front.sv @@
// front end: takes event transfers, drops unknown codes, classifies into commands
// depends on swarq_pkg
`timescale 1ns / 1ps

module swarq_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  swarq_pkg::in_item_t in_data,
	output logic               push,
	output swarq_pkg::cmd_t    push_cmd,
	input  logic               q_full
);

	logic            valid_s1;
	swarq_pkg::cmd_t cmd_s1;
	swarq_pkg::cmd_t cmd_dec;
	logic            known;

	// decode the event code
	always_comb begin
		cmd_dec               = '0;
		cmd_dec.window        = in_data.window;
		known                 = 1'b1;
		case (in_data.action)
			swarq_pkg::ACT_CHECK: begin
				cmd_dec.op = swarq_pkg::OP_CHECK;
			end
			swarq_pkg::ACT_WRITE: begin
				cmd_dec.op            = swarq_pkg::OP_WRITE;
				cmd_dec.flush_if_held = 1'b1;
			end
			swarq_pkg::ACT_ACK: begin
				cmd_dec.op            = swarq_pkg::OP_ACK;
				cmd_dec.flush_if_held = 1'b1;
			end
			swarq_pkg::ACT_NAK: begin
				cmd_dec.op            = swarq_pkg::OP_NAK;
				cmd_dec.flush_if_held = 1'b1;
			end
			swarq_pkg::ACT_EOS: begin
				cmd_dec.op           = swarq_pkg::OP_EOS;
				cmd_dec.flush_always = 1'b1;
			end
			swarq_pkg::ACT_SEND: begin
				cmd_dec.op = swarq_pkg::OP_SEND;
			end
			swarq_pkg::ACT_TIMEOUT: begin
				cmd_dec.op = swarq_pkg::OP_TIMEOUT;
			end
			default: begin
				cmd_dec.op = swarq_pkg::OP_CHECK;
				known      = 1'b0;
			end
		endcase
	end

	assign push     = valid_s1 && !q_full;
	assign push_cmd = cmd_s1;
	assign in_ready = !valid_s1 || !q_full;

	// stage register in front of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

@@ design/swarq_queue.sv @@
// two-entry command queue between front and back
// depends on swarq_pkg
`timescale 1ns / 1ps

module swarq_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  swarq_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output swarq_pkg::cmd_t head
);

	swarq_pkg::cmd_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/swarq_back.sv @@
// back end: window state and result sequencer, at most one result per cycle while the receiver takes them
// depends on swarq_pkg
`timescale 1ns / 1ps

module swarq_back #(
	parameter int WINDOWS = swarq_pkg::WINDOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  swarq_pkg::cmd_t      q_cmd,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output swarq_pkg::out_item_t out_data
);

	localparam int SW    = swarq_pkg::SEQ_W;
	localparam int IDX_W = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
	localparam int CNT_W = $clog2(WINDOWS + 1);
	localparam logic [SW-1:0]    WIN_SEQ = SW'(WINDOWS);
	localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOWS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_EXEC,
		ST_DELIVER,
		ST_ANSWER,
		ST_RETIRE,
		ST_SCAN
	} state_t;

	state_t               state_q;
	swarq_pkg::cmd_t      cmd_q;
	logic [WINDOWS-1:0]   rx_ready_q;
	logic [SW-1:0]        rx_base_q;
	logic [WINDOWS-1:0]   tx_pending_q;
	logic [SW-1:0]        tx_base_q;
	logic [CNT_W-1:0]     tx_count_q;
	logic [7:0]           check_map_q;
	logic                 check_held_q;
	logic [WINDOWS-1:0]   scan_q;
	logic                 out_valid_q;
	swarq_pkg::out_item_t out_data_q;

	logic          can_emit;
	logic          emit_now;
	logic [SW-1:0] map_idx;
	logic [7:0]    map_rest;
	logic [SW-1:0] r_map;
	logic [2:0]    map_kind;
	logic [SW-1:0] r_win;
	logic [2:0]    win_kind;
	logic [SW-1:0] r_tx;
	logic          tx_in_range;
	logic [SW-1:0] scan_idx;
	logic          last_flush;

	assign can_emit  = !out_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// answers for buffered checks and writes, nak range, timeout scan
	always_comb begin
		map_idx    = swarq_pkg::lowest_set(check_map_q);
		map_rest   = check_map_q & ~(8'd1 << map_idx);
		r_map      = map_idx - rx_base_q;
		map_kind   = ((r_map >= WIN_SEQ) || rx_ready_q[r_map[IDX_W-1:0]]) ?
			swarq_pkg::KIND_ACK : swarq_pkg::KIND_NAK;
		r_win      = cmd_q.window - rx_base_q;
		win_kind   = ((r_win >= WIN_SEQ) || rx_ready_q[r_win[IDX_W-1:0]]) ?
			swarq_pkg::KIND_ACK : swarq_pkg::KIND_NAK;
		r_tx        = cmd_q.window - tx_base_q;
		tx_in_range = r_tx < SW'(tx_count_q);
		scan_idx    = swarq_pkg::lowest_set(8'(scan_q));
		last_flush  = (map_rest == 8'd0) &&
			(cmd_q.op == swarq_pkg::OP_ACK || cmd_q.op == swarq_pkg::OP_EOS);
	end

	// a result is loaded into the output register this cycle
	always_comb begin
		case (state_q)
			ST_FLUSH: begin
				emit_now = can_emit && (check_map_q != 8'd0);
			end
			ST_EXEC: begin
				emit_now = can_emit && (cmd_q.op == swarq_pkg::OP_NAK);
			end
			ST_DELIVER: begin
				emit_now = can_emit && rx_ready_q[0];
			end
			ST_ANSWER: begin
				emit_now = can_emit;
			end
			ST_RETIRE: begin
				emit_now = can_emit && !(tx_count_q != '0 && !tx_pending_q[0]);
			end
			ST_SCAN: begin
				emit_now = can_emit;
			end
			default: begin
				emit_now = 1'b0;
			end
		endcase
	end

	// sequencer, window state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rx_ready_q   <= '0;
			rx_base_q    <= '0;
			tx_pending_q <= '0;
			tx_base_q    <= '0;
			tx_count_q   <= '0;
			check_map_q  <= '0;
			check_held_q <= 1'b0;
			scan_q       <= '0;
			out_valid_q  <= 1'b0;
			cmd_q        <= '0;
			out_data_q   <= '0;
		end else begin
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q <= q_cmd;
						if (q_cmd.flush_always || (q_cmd.flush_if_held && check_held_q)) begin
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				// answer buffered checks in ascending order
				ST_FLUSH: begin
					if (check_map_q == 8'd0) begin
						check_held_q <= 1'b0;
						state_q      <= ST_EXEC;
					end else if (can_emit) begin
						out_data_q.kind <= map_kind;
						out_data_q.seq  <= map_idx;
						out_data_q.last <= last_flush;
						check_map_q     <= map_rest;
					end
				end
				ST_EXEC: begin
					case (cmd_q.op)
						swarq_pkg::OP_CHECK: begin
							check_map_q  <= check_map_q | (8'd1 << cmd_q.window);
							check_held_q <= 1'b1;
							state_q      <= ST_IDLE;
						end
						swarq_pkg::OP_WRITE: begin
							if (r_win < WIN_SEQ) begin
								rx_ready_q[r_win[IDX_W-1:0]] <= 1'b1;
							end
							state_q <= ST_DELIVER;
						end
						swarq_pkg::OP_ACK: begin
							if (tx_in_range) begin
								tx_pending_q[r_tx[IDX_W-1:0]] <= 1'b0;
							end
							state_q <= ST_IDLE;
						end
						swarq_pkg::OP_NAK: begin
							if (can_emit) begin
								out_data_q.kind <= tx_in_range ?
									swarq_pkg::KIND_XMIT : swarq_pkg::KIND_ILLNAK;
								out_data_q.seq  <= cmd_q.window;
								out_data_q.last <= 1'b1;
								state_q         <= ST_IDLE;
							end
						end
						swarq_pkg::OP_SEND: begin
							state_q <= ST_RETIRE;
						end
						swarq_pkg::OP_TIMEOUT: begin
							scan_q  <= tx_pending_q;
							state_q <= (tx_pending_q == '0) ? ST_IDLE : ST_SCAN;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				// hand up in-order receive windows
				ST_DELIVER: begin
					if (!rx_ready_q[0]) begin
						state_q <= ST_ANSWER;
					end else if (can_emit) begin
						out_data_q.kind <= swarq_pkg::KIND_DELIVER;
						out_data_q.seq  <= rx_base_q;
						out_data_q.last <= 1'b0;
						rx_ready_q      <= rx_ready_q >> 1;
						rx_base_q       <= rx_base_q + SW'(1);
					end
				end
				ST_ANSWER: begin
					if (can_emit) begin
						out_data_q.kind <= win_kind;
						out_data_q.seq  <= cmd_q.window;
						out_data_q.last <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				// retire acknowledged slots at the head, then claim one or report the window full
				ST_RETIRE: begin
					if (tx_count_q != '0 && !tx_pending_q[0]) begin
						tx_pending_q <= tx_pending_q >> 1;
						tx_count_q   <= tx_count_q - CNT_W'(1);
						tx_base_q    <= tx_base_q + SW'(1);
					end else if (can_emit) begin
						out_data_q.last <= 1'b1;
						if (tx_count_q < WIN_CNT) begin
							out_data_q.kind                     <= swarq_pkg::KIND_XMIT;
							out_data_q.seq                      <= tx_base_q + SW'(tx_count_q);
							tx_pending_q[tx_count_q[IDX_W-1:0]] <= 1'b1;
							tx_count_q                          <= tx_count_q + CNT_W'(1);
						end else begin
							out_data_q.kind <= swarq_pkg::KIND_FULL;
							out_data_q.seq  <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				// resend checks for unacknowledged slots, then arm the timer
				ST_SCAN: begin
					if (can_emit) begin
						if (scan_q != '0) begin
							out_data_q.kind <= swarq_pkg::KIND_CHECK;
							out_data_q.seq  <= tx_base_q + scan_idx;
							out_data_q.last <= 1'b0;
							scan_q          <= scan_q & ~(WINDOWS'(1) << scan_idx);
						end else begin
							out_data_q.kind <= swarq_pkg::KIND_ARM;
							out_data_q.seq  <= '0;
							out_data_q.last <= 1'b1;
							state_q         <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ design/sliding_window_arq_control.sv @@
// sliding window arq control: an event transfer passes the front stage register, the command
// queue and the back sequencer into the output register; a send also waits while acknowledged
// slots retire, and any event may wait in the queue. results follow at most one per cycle while
// the receiver takes them. the back sequencer sets the rate: it pops a new command only in its
// idle state, once the last one is done. reset clears the control state and empties the queue.
// depends on swarq_pkg, swarq_front, swarq_queue, swarq_back
`timescale 1ns / 1ps

module sliding_window_arq_control #(
	parameter int WINDOWS = swarq_pkg::WINDOWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  swarq_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output swarq_pkg::out_item_t out_data
);

	logic            push;
	swarq_pkg::cmd_t push_cmd;
	logic            q_full;
	logic            pop;
	logic            q_valid;
	swarq_pkg::cmd_t q_cmd;

	// event decode
	swarq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	// command queue
	swarq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (q_cmd)
	);

	// window state and result sequencer
	swarq_back #(
		.WINDOWS (WINDOWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
